/* rtl/mpr_pkg.sv */
`default_nettype none
package mpr_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_COUNT  = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_SEARCH = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	localparam int IDX_W = 7;
	localparam int NUM_W = 6;

	typedef struct packed {
		logic             done;
		logic             found;
		logic [NUM_W-1:0] entry_number;
	} result_t;

endpackage
`default_nettype wire

/* rtl/multidim_prefix_region_lookup_top.sv */
`default_nettype none
// Non-search words: result registered, done in the cycle after accept; one word per cycle while idle.
// Search: one entry row read from the directory memory per cycle; the first hit in
// entry order reports its number, a miss ends after the last live entry (no scan if empty).
// Results pulse done for one cycle; the receiver cannot stall.
// Reset: count and query keys zero, key count 1; directory undefined until written.
module multidim_prefix_region_lookup_top #(
	parameter int MAX_ENTRIES = 64,
	parameter int MAX_KEYS    = 4,
	parameter int HASH_BITS   = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [1:0]  command,
	input  wire logic [5:0]  entry_index,
	input  wire logic [1:0]  dimension,
	input  wire logic [5:0]  prefix_length,
	input  wire logic [31:0] hash_value,
	input  wire logic [6:0]  entry_count,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_wdata,
	output      logic        done,
	output      logic        found,
	output      logic [5:0]  entry_number
);

	localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic                                  wr_en;
	logic [RW-1:0]                         wr_row;
	logic [MAX_KEYS-1:0]                   wr_lanes;
	logic [2*HASH_BITS-1:0]                wr_word;
	logic                                  rd_en;
	logic [RW-1:0]                         rd_row;
	logic [MAX_KEYS-1:0][2*HASH_BITS-1:0]  rd_data;
	mpr_pkg::result_t                      res;

	mpr_seq #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.MAX_KEYS    (MAX_KEYS),
		.HB          (HASH_BITS),
		.RW          (RW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.entry_index   (entry_index),
		.dimension     (dimension),
		.prefix_length (prefix_length),
		.hash_value    (hash_value),
		.entry_count   (entry_count),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.wr_en         (wr_en),
		.wr_row        (wr_row),
		.wr_lanes      (wr_lanes),
		.wr_word       (wr_word),
		.rd_en         (rd_en),
		.rd_row        (rd_row),
		.rd_data       (rd_data),
		.res           (res)
	);

	mpr_dir_mem #(
		.ROWS  (MAX_ENTRIES),
		.LANES (MAX_KEYS),
		.HB    (HASH_BITS),
		.RW    (RW)
	) u_mem (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_row   (wr_row),
		.wr_lanes (wr_lanes),
		.wr_word  (wr_word),
		.rd_en    (rd_en),
		.rd_row   (rd_row),
		.rd_data  (rd_data)
	);

	assign done         = res.done;
	assign found        = res.found;
	assign entry_number = res.entry_number;

endmodule
`default_nettype wire

/* rtl/mpr_dir_mem.sv */
`default_nettype none
// Directory memory: one row per entry, one lane per key dimension.
// Lane word is {mask, masked hash}. Lane-enabled write, registered row read.
module mpr_dir_mem #(
	parameter int ROWS  = 64,
	parameter int LANES = 4,
	parameter int HB    = 32,
	parameter int RW    = 6
) (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [RW-1:0]                wr_row,
	input  wire logic [LANES-1:0]             wr_lanes,
	input  wire logic [2*HB-1:0]              wr_word,
	input  wire logic                         rd_en,
	input  wire logic [RW-1:0]                rd_row,
	output      logic [LANES-1:0][2*HB-1:0]   rd_data
);

	logic [LANES-1:0][2*HB-1:0] mem_q [ROWS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int l = 0; l < LANES; l++) begin
				if (wr_lanes[l]) begin
					mem_q[wr_row][l] <= wr_word;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_row];
		end
	end

endmodule
`default_nettype wire

/* rtl/mpr_seq.sv */
`default_nettype none
// Command decode, query key and count registers, and the search scan.
module mpr_seq #(
	parameter int MAX_ENTRIES = 64,
	parameter int MAX_KEYS    = 4,
	parameter int HB          = 32,
	parameter int RW          = 6
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output      logic                           busy,
	input  wire logic [1:0]                     command,
	input  wire logic [5:0]                     entry_index,
	input  wire logic [1:0]                     dimension,
	input  wire logic [5:0]                     prefix_length,
	input  wire logic [31:0]                    hash_value,
	input  wire logic [6:0]                     entry_count,
	input  wire logic                           cfg_we,
	input  wire logic [2:0]                     cfg_wdata,
	output      logic                           wr_en,
	output      logic [RW-1:0]                  wr_row,
	output      logic [MAX_KEYS-1:0]            wr_lanes,
	output      logic [2*HB-1:0]                wr_word,
	output      logic                           rd_en,
	output      logic [RW-1:0]                  rd_row,
	input  wire logic [MAX_KEYS-1:0][2*HB-1:0]  rd_data,
	output      mpr_pkg::result_t               res
);

	mpr_pkg::state_t              state_q;
	mpr_pkg::cmd_t                cmd;
	mpr_pkg::result_t             res_q;
	logic [2:0]                   num_keys_q;
	logic [mpr_pkg::IDX_W-1:0]    live_q;
	logic [mpr_pkg::IDX_W-1:0]    idx_s1;
	logic [HB-1:0]                qkey_q [MAX_KEYS];
	logic [HB-1:0]                hash_in;
	logic [HB-1:0]                mask_in;
	logic [mpr_pkg::IDX_W-1:0]    live_sat;
	logic                         accept;
	logic                         dim_ok;
	logic                         hit;
	logic [MAX_KEYS-1:0]          lane_ok;

	always_comb begin
		cmd     = mpr_pkg::cmd_t'(command);
		accept  = start && (state_q == mpr_pkg::ST_IDLE);
		hash_in = HB'(hash_value);
		// shift by HB or more leaves zero, so long prefixes compare full width
		mask_in = ~({HB{1'b1}} >> prefix_length);
		dim_ok  = 32'(dimension) < 32'(MAX_KEYS);
		live_sat = (32'(entry_count) > 32'(MAX_ENTRIES)) ?
			mpr_pkg::IDX_W'(MAX_ENTRIES) : entry_count;

		for (int l = 0; l < MAX_KEYS; l++) begin
			wr_lanes[l] = (32'(dimension) == l);
		end
		wr_en   = accept && (cmd == mpr_pkg::CMD_WRITE) && dim_ok &&
			(32'(entry_index) < 32'(MAX_ENTRIES));
		wr_row  = RW'(entry_index);
		wr_word = {mask_in, hash_in & mask_in};

		// prefetch the next row each scan cycle; reads past the live range are dropped
		if (state_q == mpr_pkg::ST_SCAN) begin
			rd_en  = 1'b1;
			rd_row = RW'(idx_s1 + 7'd1);
		end else begin
			rd_en  = accept && (cmd == mpr_pkg::CMD_SEARCH) && (live_q != '0);
			rd_row = '0;
		end

		for (int l = 0; l < MAX_KEYS; l++) begin
			lane_ok[l] = (32'(l) >= 32'(num_keys_q)) ||
				((qkey_q[l] & rd_data[l][2*HB-1:HB]) == rd_data[l][HB-1:0]);
		end
		hit = &lane_ok;

		busy = (state_q == mpr_pkg::ST_SCAN);
		res  = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_keys_q <= 3'd1;
		end else if (cfg_we) begin
			num_keys_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpr_pkg::ST_IDLE;
			res_q   <= '0;
			live_q  <= '0;
			idx_s1  <= '0;
			for (int l = 0; l < MAX_KEYS; l++) begin
				qkey_q[l] <= '0;
			end
		end else begin
			res_q.done <= 1'b0;
			unique case (state_q)
				mpr_pkg::ST_IDLE: begin
					if (start) begin
						res_q.found        <= 1'b0;
						res_q.entry_number <= '0;
						unique case (cmd)
							mpr_pkg::CMD_WRITE: begin
								res_q.done <= 1'b1;
							end
							mpr_pkg::CMD_COUNT: begin
								live_q     <= live_sat;
								res_q.done <= 1'b1;
							end
							mpr_pkg::CMD_QUERY: begin
								for (int l = 0; l < MAX_KEYS; l++) begin
									if (wr_lanes[l]) begin
										qkey_q[l] <= hash_in;
									end
								end
								res_q.done <= 1'b1;
							end
							mpr_pkg::CMD_SEARCH: begin
								if (live_q == '0) begin
									res_q.done <= 1'b1;
								end else begin
									idx_s1  <= '0;
									state_q <= mpr_pkg::ST_SCAN;
								end
							end
							default: begin
								res_q.done <= 1'b1;
							end
						endcase
					end
				end
				mpr_pkg::ST_SCAN: begin
					priority if (hit) begin
						res_q.done         <= 1'b1;
						res_q.found        <= 1'b1;
						res_q.entry_number <= idx_s1[mpr_pkg::NUM_W-1:0];
						state_q            <= mpr_pkg::ST_IDLE;
					end else if ((idx_s1 + 7'd1) == live_q) begin
						res_q.done <= 1'b1;
						state_q    <= mpr_pkg::ST_IDLE;
					end else begin
						idx_s1 <= idx_s1 + 7'd1;
					end
				end
				default: begin
					state_q <= mpr_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
